// ===== sv/lmb_pkg.sv =====
// lmb_pkg: shared types, constants and helper functions of the Legendre moment binner.
// Used by lmb_poly, lmb_ctrl, lmb_dp and the top module; depends on nothing.
`default_nettype none
package lmb_pkg;

   localparam int MAX_BINS   = 64;
   localparam int NUM_ORDERS = 7;
   localparam int SUM_WIDTH  = 40;
   localparam int BIN_W      = $clog2(MAX_BINS);
   localparam int NB_W       = 7;
   localparam int ROW_W      = NUM_ORDERS * SUM_WIDTH;
   localparam int P_W        = 18;
   localparam int WIDE_W     = 60;
   localparam int A_W        = 40;
   localparam int CTR_W      = 22;
   localparam int PADDR_W    = 5;
   localparam int PDATA_W    = 32;

   localparam logic [1:0] OP_EVENT = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] SEL_ONE = 2'd0;
   localparam logic [1:0] SEL_TWO = 2'd1;

   localparam logic [2:0] REG_FIRST_CENTER = 3'd0;
   localparam logic [2:0] REG_BIN_STEP     = 3'd1;
   localparam logic [2:0] REG_HALF_WIDTH   = 3'd2;
   localparam logic [2:0] REG_NUM_BINS     = 3'd3;
   localparam logic [2:0] REG_BEAM_CENTER  = 3'd4;
   localparam logic [2:0] REG_BEAM_HALF    = 3'd5;

   localparam logic signed [WIDE_W-1:0] Q28 = WIDE_W'(64'sd268435456);

   typedef logic [NUM_ORDERS-1:0][SUM_WIDTH-1:0] row_type;
   typedef logic [NUM_ORDERS-1:0][P_W-1:0]       pvec_type;

   typedef struct packed {
      logic [15:0]   first_bin_center;
      logic [15:0]   bin_step;
      logic [15:0]   half_width;
      logic [NB_W-1:0] num_bins;
      logic [15:0]   beam_center;
      logic [15:0]   beam_half_window;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic scan_start;
      logic scan;
      logic scan_eval;
      logic scan_write;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic nb_zero;
      logic out_full;
   } status_type;

   function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [WIDE_W-1:0] v,
                                                    input int n);
      logic signed [WIDE_W-1:0] half;
      half = WIDE_W'(64'sd1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                    input logic [SUM_WIDTH-1:0] b);
      logic [SUM_WIDTH:0] s;
      s = {a[SUM_WIDTH-1], a} + {b[SUM_WIDTH-1], b};
      if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
         return s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end
      return s[SUM_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/lmb_ram.sv =====
// lmb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== sv/lmb_poly.sv =====
// lmb_poly: five-stage fixed-point pipeline for P0..P6 at x = -cos (Q14 in, Q14 out).
// Depends on lmb_pkg.
`default_nettype none
module lmb_poly (
   input  wire logic               clock,
   input  wire logic signed [15:0] cos_in,
   output lmb_pkg::pvec_type       p
);
   import lmb_pkg::*;

   logic signed [16:0]        x;
   logic signed [33:0]        xx;
   logic [28:0]               u_ff;
   logic signed [WIDE_W-1:0]  uw, a4, a5, a6, a6b, p3m_in;
   logic signed [15:0]        hi;
   logic signed [15:0]        lo;
   logic signed [WIDE_W-1:0]  p2_ff, p3m_ff, p3_ff, p4_ff, p5m_ff, p5_ff, p6_ff;
   logic signed [WIDE_W-1:0]  ahi4_ff, alo4_ff, ahi5_ff, alo5_ff, ahi6_ff, alo6_ff;
   logic signed [WIDE_W-1:0]  m4_ff, m5_ff, m6_ff, bhi_ff, blo_ff;
   logic signed [WIDE_W-1:0]  p2_q, p3_q;
   logic signed [WIDE_W-1:0]  m5q;
   logic signed [WIDE_W-1:0]  b6;

   always_comb begin
      if (cos_in > 16'sd16384) begin
         x = -17'sd16384;
      end else if (cos_in < -16'sd16384) begin
         x = 17'sd16384;
      end else begin
         x = -{cos_in[15], cos_in};
      end
      xx  = x * x;
      uw  = WIDE_W'(u_ff);
      hi  = $signed({1'b0, u_ff[28:14]});
      lo  = $signed({2'b0, u_ff[13:0]});
      a4  = 35 * uw - 30 * Q28;
      a5  = 63 * uw - 70 * Q28;
      a6  = 231 * uw - 315 * Q28;
      p3m_in = 5 * uw - 3 * Q28;
      p2_q = rnd(3 * uw - Q28, 15);
      p3_q = rnd(p3m_ff, 29);
      m5q  = m5_ff + 15 * Q28;
      b6   = m6_ff + 105 * Q28;
      a6b  = b6;
   end

   always_ff @(posedge clock) begin
      u_ff    <= xx[28:0];
      p2_ff   <= p2_q;
      p3m_ff  <= $signed(p3m_in[31:0]) * x;
      ahi4_ff <= $signed(a4[A_W-1:0]) * hi;
      alo4_ff <= $signed(a4[A_W-1:0]) * lo;
      ahi5_ff <= $signed(a5[A_W-1:0]) * hi;
      alo5_ff <= $signed(a5[A_W-1:0]) * lo;
      ahi6_ff <= $signed(a6[A_W-1:0]) * hi;
      alo6_ff <= $signed(a6[A_W-1:0]) * lo;
      m4_ff   <= rnd(ahi4_ff + rnd(alo4_ff, 14), 14);
      m5_ff   <= rnd(ahi5_ff + rnd(alo5_ff, 14), 14);
      m6_ff   <= rnd(ahi6_ff + rnd(alo6_ff, 14), 14);
      p3_ff   <= p3_q;
      p4_ff   <= rnd(m4_ff + 3 * Q28, 17);
      p5m_ff  <= $signed(m5q[A_W-1:0]) * x;
      bhi_ff  <= $signed(a6b[A_W-1:0]) * hi;
      blo_ff  <= $signed(a6b[A_W-1:0]) * lo;
      p5_ff   <= rnd(p5m_ff, 31);
      p6_ff   <= rnd(rnd(bhi_ff + rnd(blo_ff, 14), 14) - 5 * Q28, 18);
   end

   assign p[0] = P_W'(18'sd16384);
   assign p[1] = P_W'(x);
   assign p[2] = p2_ff[P_W-1:0];
   assign p[3] = p3_ff[P_W-1:0];
   assign p[4] = p4_ff[P_W-1:0];
   assign p[5] = p5_ff[P_W-1:0];
   assign p[6] = p6_ff[P_W-1:0];
endmodule
`default_nettype wire

// ===== sv/lmb_ctrl.sv =====
// lmb_ctrl: sequencer for event, read and clear words of the moment binner.
// Depends on lmb_pkg.
`default_nettype none
module lmb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_op,
   output logic                     req_stall,
   input  wire lmb_pkg::status_type status,
   output lmb_pkg::cmd_type         cmd
);
   import lmb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_POLY, ST_SCAN_RD, ST_SCAN_WR, ST_READ, ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load  = accept;
            cmd.clear = accept && (req_op == OP_CLEAR);
            cnt_in    = '0;
            if (accept && req_op == OP_EVENT) begin
               state_in = ST_POLY;
            end else if (accept && req_op == OP_READ) begin
               state_in = ST_READ;
            end
         end
         ST_POLY: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               cmd.scan_start = 1'b1;
               state_in = status.nb_zero ? ST_IDLE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan      = 1'b1;
            cmd.scan_eval = 1'b1;
            state_in      = ST_SCAN_WR;
         end
         ST_SCAN_WR: begin
            cmd.scan       = 1'b1;
            cmd.scan_write = 1'b1;
            state_in       = status.scan_last ? ST_IDLE : ST_SCAN_RD;
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/lmb_dp.sv =====
// lmb_dp: datapath of the moment binner: word capture, polynomial units, bin scan,
// sum RAMs with row valid bits, saturating update and result register.
// Depends on lmb_pkg, lmb_poly and lmb_ram.
`default_nettype none
module lmb_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lmb_pkg::cfg_type     cfg,
   input  wire lmb_pkg::cmd_type     cmd,
   output lmb_pkg::status_type       status,
   input  wire logic [15:0]          req_beam_value,
   input  wire logic [15:0]          req_mass_first,
   input  wire logic [15:0]          req_mass_second,
   input  wire logic signed [15:0]   req_cos_first,
   input  wire logic signed [15:0]   req_cos_second,
   input  wire logic [5:0]           req_bin_select,
   input  wire logic [1:0]           req_set_select,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [5:0]                rsp_bin_echo,
   output lmb_pkg::row_type          rsp_sums
);
   import lmb_pkg::*;

   logic [15:0]        beam_ff, mass1_ff, mass2_ff;
   logic signed [15:0] cos1_ff, cos2_ff;
   logic [BIN_W-1:0]   bin_sel_ff, bin_ff, raddr;
   logic [1:0]         set_sel_ff;
   logic [CTR_W-1:0]   center_ff;
   logic               hit1_ff, hit2_ff;
   logic [MAX_BINS-1:0] valid1_ff, valid2_ff;
   logic               vld1_ff, vld2_ff;
   pvec_type           p1, p2;
   row_type            rd1, rd2, old1, old2, wr1, wr2, rsum;
   logic [ROW_W-1:0]   rd1_raw, rd2_raw;
   logic               out_valid_ff;
   logic [5:0]         out_bin_ff;
   row_type            out_sum_ff;
   logic [NB_W-1:0]    nb;
   logic signed [16:0] bd;
   logic [16:0]        bd_abs;
   logic signed [CTR_W:0] d1, d2;
   logic [CTR_W:0]     d1_abs, d2_abs;
   logic               beam_ok, hit1, hit2;

   lmb_poly u_poly1 (.clock(clock), .cos_in(cos1_ff), .p(p1));
   lmb_poly u_poly2 (.clock(clock), .cos_in(cos2_ff), .p(p2));

   lmb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BINS)) u_ram1 (
      .clock(clock), .we(cmd.scan_write && hit1_ff), .waddr(bin_ff), .wdata(wr1),
      .raddr(raddr), .rdata(rd1_raw)
   );
   lmb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BINS)) u_ram2 (
      .clock(clock), .we(cmd.scan_write && hit2_ff), .waddr(bin_ff), .wdata(wr2),
      .raddr(raddr), .rdata(rd2_raw)
   );

   always_comb begin
      nb     = (cfg.num_bins > NB_W'(MAX_BINS)) ? NB_W'(MAX_BINS) : cfg.num_bins;
      raddr  = cmd.scan ? bin_ff : bin_sel_ff;
      bd     = $signed({1'b0, beam_ff}) - $signed({1'b0, cfg.beam_center});
      bd_abs = bd[16] ? 17'(-bd) : 17'(bd);
      beam_ok = bd_abs < {1'b0, cfg.beam_half_window};
      d1     = $signed({7'b0, mass1_ff}) - $signed({1'b0, center_ff});
      d2     = $signed({7'b0, mass2_ff}) - $signed({1'b0, center_ff});
      d1_abs = d1[CTR_W] ? (CTR_W+1)'(-d1) : (CTR_W+1)'(d1);
      d2_abs = d2[CTR_W] ? (CTR_W+1)'(-d2) : (CTR_W+1)'(d2);
      hit1   = d1_abs < (CTR_W+1)'(cfg.half_width);
      hit2   = beam_ok && (d2_abs < (CTR_W+1)'(cfg.half_width));
      rd1    = rd1_raw;
      rd2    = rd2_raw;
      for (int k = 0; k < NUM_ORDERS; k++) begin
         old1[k] = vld1_ff ? rd1[k] : '0;
         old2[k] = vld2_ff ? rd2[k] : '0;
         wr1[k]  = sat_add(old1[k], SUM_WIDTH'($signed(p1[k])));
         wr2[k]  = sat_add(old2[k], SUM_WIDTH'($signed(p2[k])));
         case (set_sel_ff)
            SEL_ONE: rsum[k] = old1[k];
            SEL_TWO: rsum[k] = old2[k];
            default: rsum[k] = sat_add(old1[k], old2[k]);
         endcase
      end
      status.scan_last = ({1'b0, bin_ff} == nb - NB_W'(1));
      status.nb_zero   = (nb == '0);
      status.out_full  = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         beam_ff    <= req_beam_value;
         mass1_ff   <= req_mass_first;
         mass2_ff   <= req_mass_second;
         cos1_ff    <= req_cos_first;
         cos2_ff    <= req_cos_second;
         bin_sel_ff <= req_bin_select;
         set_sel_ff <= req_set_select;
      end
      if (cmd.scan_start) begin
         bin_ff    <= '0;
         center_ff <= CTR_W'(cfg.first_bin_center);
      end else if (cmd.scan_write) begin
         bin_ff    <= bin_ff + BIN_W'(1);
         center_ff <= center_ff + CTR_W'(cfg.bin_step);
      end
      if (cmd.scan_eval) begin
         hit1_ff <= hit1;
         hit2_ff <= hit2;
      end
      vld1_ff <= valid1_ff[raddr];
      vld2_ff <= valid2_ff[raddr];
      if (cmd.out_load) begin
         out_bin_ff <= bin_sel_ff;
         out_sum_ff <= rsum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid1_ff <= '0;
         valid2_ff <= '0;
      end else if (cmd.scan_write) begin
         if (hit1_ff) valid1_ff[bin_ff] <= 1'b1;
         if (hit2_ff) valid2_ff[bin_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_bin_echo = out_bin_ff;
   assign rsp_sums     = out_sum_ff;

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (valid1_ff == '0 && valid2_ff == '0)) else $error("rows valid after clear");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_write |-> ({1'b0, bin_ff} < nb)) else $error("write beyond bins in use");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_valid_ff) else $error("result overwritten");
endmodule
`default_nettype wire

// ===== sv/legendre_moment_binner_top.sv =====
// legendre_moment_binner_top: Legendre moment histogram over mass bins.
// Holds the configuration registers; depends on lmb_pkg, lmb_ctrl and lmb_dp.
//
// Usage: words enter on req_* (valid/stall), results leave on rsp_* (valid/stall).
// An event word evaluates P0..P6 for both cosines in the polynomial pipeline,
// then scans the bins in use, each with a RAM read, then saturating add and
// write-back. Both sets are updated in the same scan. A clear word resets the
// per-row valid bits, so all sums read as zero afterward (no sweep). A read word
// gives one result word with the seven sums of one bin.
// One word is in work at a time; req_stall is high while a word is in work.
// A finished result waits in the output register while rsp_stall is high; the
// next event or clear word is taken meanwhile, a further read waits for it.
// Reset (synchronous) restores the register defaults and empties all sums.
// Registers sit at byte address 4*i on the APB-style port; pready is always high.
`default_nettype none
module legendre_moment_binner_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_op,
   input  wire logic [15:0]                   req_beam_value,
   input  wire logic [15:0]                   req_mass_first,
   input  wire logic [15:0]                   req_mass_second,
   input  wire logic signed [15:0]            req_cos_first,
   input  wire logic signed [15:0]            req_cos_second,
   input  wire logic [5:0]                    req_bin_select,
   input  wire logic [1:0]                    req_set_select,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [5:0]                         rsp_bin_echo,
   output logic signed [lmb_pkg::SUM_WIDTH-1:0] rsp_sum_p0,
   output logic signed [lmb_pkg::SUM_WIDTH-1:0] rsp_sum_p1,
   output logic signed [lmb_pkg::SUM_WIDTH-1:0] rsp_sum_p2,
   output logic signed [lmb_pkg::SUM_WIDTH-1:0] rsp_sum_p3,
   output logic signed [lmb_pkg::SUM_WIDTH-1:0] rsp_sum_p4,
   output logic signed [lmb_pkg::SUM_WIDTH-1:0] rsp_sum_p5,
   output logic signed [lmb_pkg::SUM_WIDTH-1:0] rsp_sum_p6,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lmb_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [lmb_pkg::PDATA_W-1:0]   pwdata,
   output logic [lmb_pkg::PDATA_W-1:0]        prdata,
   output logic                               pready
);
   import lmb_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   row_type    sums;
   logic       wr_en;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_bin_center <= 16'd18150;
         cfg_ff.bin_step         <= 16'd100;
         cfg_ff.half_width       <= 16'd50;
         cfg_ff.num_bins         <= NB_W'(50);
         cfg_ff.beam_center      <= 16'd0;
         cfg_ff.beam_half_window <= 16'd5000;
      end else if (wr_en) begin
         unique case (idx)
            REG_FIRST_CENTER: cfg_ff.first_bin_center <= pwdata[15:0];
            REG_BIN_STEP:     cfg_ff.bin_step         <= pwdata[15:0];
            REG_HALF_WIDTH:   cfg_ff.half_width       <= pwdata[15:0];
            REG_NUM_BINS:     cfg_ff.num_bins         <= pwdata[NB_W-1:0];
            REG_BEAM_CENTER:  cfg_ff.beam_center      <= pwdata[15:0];
            REG_BEAM_HALF:    cfg_ff.beam_half_window <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FIRST_CENTER: prdata = PDATA_W'(cfg_ff.first_bin_center);
         REG_BIN_STEP:     prdata = PDATA_W'(cfg_ff.bin_step);
         REG_HALF_WIDTH:   prdata = PDATA_W'(cfg_ff.half_width);
         REG_NUM_BINS:     prdata = PDATA_W'(cfg_ff.num_bins);
         REG_BEAM_CENTER:  prdata = PDATA_W'(cfg_ff.beam_center);
         REG_BEAM_HALF:    prdata = PDATA_W'(cfg_ff.beam_half_window);
         default:          prdata = '0;
      endcase
   end

   lmb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_op(req_op),
      .req_stall(req_stall), .status(status), .cmd(cmd)
   );

   lmb_dp u_dp (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd(cmd), .status(status),
      .req_beam_value(req_beam_value), .req_mass_first(req_mass_first),
      .req_mass_second(req_mass_second), .req_cos_first(req_cos_first),
      .req_cos_second(req_cos_second), .req_bin_select(req_bin_select),
      .req_set_select(req_set_select), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bin_echo(rsp_bin_echo), .rsp_sums(sums)
   );

   assign rsp_sum_p0 = sums[0];
   assign rsp_sum_p1 = sums[1];
   assign rsp_sum_p2 = sums[2];
   assign rsp_sum_p3 = sums[3];
   assign rsp_sum_p4 = sums[4];
   assign rsp_sum_p5 = sums[5];
   assign rsp_sum_p6 = sums[6];
endmodule
`default_nettype wire
